/* rtl/tok_pkg.sv */
// ----------------------------------------------------------------------------
// tok_pkg
// Shared types, character codes and keyword table for the query tokenizer.
// ----------------------------------------------------------------------------
package tok_pkg;

  localparam int LINE_BITS_DEF       = 16;
  localparam int MAX_KEYWORD_LEN_DEF = 7;
  localparam int KEYWORD_COUNT_DEF   = 14;

  localparam int KIND_W     = 3;
  localparam int KW_IDX_W   = 4;
  localparam int NUM_W      = 31;
  localparam int CHAR_W     = 8;
  localparam int LINE_OUT_W = 16;

  localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUMBER,
    MODE_WORD,
    MODE_REGEX
  } tok_mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_NUMBER,
    KIND_IDENT,
    KIND_KEYWORD,
    KIND_REGEX_END,
    KIND_SINGLE,
    KIND_TEXT,
    KIND_UNTERM
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e              kind;
    logic [KW_IDX_W-1:0]    kw_idx;
    logic [NUM_W-1:0]       num;
    logic                   sat;
    logic [CHAR_W-1:0]      chr;
    logic [LINE_OUT_W-1:0]  line;
    logic                   last;
  } tok_result_t;

  localparam int KW_TABLE_SIZE = 14;
  localparam int KW_TEXT_W     = 56;

  localparam logic [KW_TEXT_W-1:0] KW_TEXT [KW_TABLE_SIZE] = '{
    "create", "view", "as", "output", "select", "from", "extract",
    "regex", "on", "return", "group", "and", "Token", "pattern"
  };

  localparam logic [3:0] KW_LEN [KW_TABLE_SIZE] = '{
    4'd6, 4'd4, 4'd2, 4'd6, 4'd6, 4'd4, 4'd7,
    4'd5, 4'd2, 4'd6, 4'd5, 4'd3, 4'd5, 4'd7
  };

  function automatic tok_result_t make_result(
    tok_kind_e             kind,
    logic [KW_IDX_W-1:0]   kw_idx,
    logic [NUM_W-1:0]      num,
    logic                  sat,
    logic [CHAR_W-1:0]     chr,
    logic [LINE_OUT_W-1:0] line
  );
    tok_result_t r;
    r.kind   = kind;
    r.kw_idx = kw_idx;
    r.num    = num;
    r.sat    = sat;
    r.chr    = chr;
    r.line   = line;
    r.last   = 1'b0;
    return r;
  endfunction

endpackage

/* rtl/tok_kwmatch.sv */
// ----------------------------------------------------------------------------
// tok_kwmatch
// Parallel compare of the buffered word prefix against the keyword table.
// ----------------------------------------------------------------------------
module tok_kwmatch #(
  parameter int MAX_KEYWORD_LEN = 7,
  parameter int KEYWORD_COUNT   = 14,
  parameter int WLEN_W          = 4
) (
  input  logic [MAX_KEYWORD_LEN*8-1:0]  word_buf_i,
  input  logic [WLEN_W-1:0]             wlen_i,
  output logic                          hit_o,
  output logic [tok_pkg::KW_IDX_W-1:0]  idx_o
);
  import tok_pkg::*;

  localparam int KwUsed = (KEYWORD_COUNT < KW_TABLE_SIZE) ? KEYWORD_COUNT : KW_TABLE_SIZE;

  logic [KwUsed-1:0] hit_vec;

  for (genvar k = 0; k < KwUsed; k++) begin : g_kw
    localparam int Len = int'(KW_LEN[k]);
    logic [MAX_KEYWORD_LEN-1:0] byte_ok;
    for (genvar j = 0; j < MAX_KEYWORD_LEN; j++) begin : g_byte
      if (j < Len) begin : g_cmp
        assign byte_ok[j] = (word_buf_i[8*j +: 8] == KW_TEXT[k][8*(Len-1-j) +: 8]);
      end else begin : g_pad
        assign byte_ok[j] = 1'b1;
      end
    end
    assign hit_vec[k] = (32'(wlen_i) == Len) && (Len <= MAX_KEYWORD_LEN) && (&byte_ok);
  end

  always_comb begin
    hit_o = |hit_vec;
    idx_o = '0;
    for (int k = KwUsed - 1; k >= 0; k--) begin
      if (hit_vec[k]) begin
        idx_o = KW_IDX_W'(k);
      end
    end
  end

endmodule

/* rtl/tok_step.sv */
// ----------------------------------------------------------------------------
// tok_step
// Single-pass scan step: next scanner state and up to two results per request.
// ----------------------------------------------------------------------------
module tok_step #(
  parameter int LINE_BITS       = 16,
  parameter int MAX_KEYWORD_LEN = 7,
  parameter int KEYWORD_COUNT   = 14,
  parameter int WLEN_W          = 4
) (
  input  logic                           op_i,
  input  logic [7:0]                     ch_i,
  input  tok_pkg::tok_mode_e             mode_q_i,
  input  logic [tok_pkg::NUM_W-1:0]      acc_q_i,
  input  logic                           ovf_q_i,
  input  logic [WLEN_W-1:0]              wlen_q_i,
  input  logic                           bs_q_i,
  input  logic [MAX_KEYWORD_LEN*8-1:0]   word_buf_q_i,
  input  logic [LINE_BITS-1:0]           line_q_i,
  output tok_pkg::tok_mode_e             mode_d_o,
  output logic [tok_pkg::NUM_W-1:0]      acc_d_o,
  output logic                           ovf_d_o,
  output logic [WLEN_W-1:0]              wlen_d_o,
  output logic                           bs_d_o,
  output logic [MAX_KEYWORD_LEN*8-1:0]   word_buf_d_o,
  output logic [LINE_BITS-1:0]           line_d_o,
  output logic [1:0]                     push_n_o,
  output tok_pkg::tok_result_t           res0_o,
  output tok_pkg::tok_result_t           res1_o
);
  import tok_pkg::*;

  localparam int AccW = NUM_W + 4;

  logic                  is_end, is_digit, is_alpha, is_alnum, is_blank, is_nl;
  logic                  is_slash, is_bslash, regex_close;
  logic                  tok_close, fresh, first_vld, second_vld;
  logic [3:0]            digit;
  logic [AccW-1:0]       acc_ext, acc_mul;
  logic                  kw_hit;
  logic [KW_IDX_W-1:0]   kw_idx;
  logic [LINE_OUT_W-1:0] line_out;
  logic [LINE_BITS+LINE_OUT_W-1:0] line_wide;
  tok_result_t           first_res, second_res, word_end_res;

  tok_kwmatch #(
    .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN),
    .KEYWORD_COUNT   (KEYWORD_COUNT),
    .WLEN_W          (WLEN_W)
  ) u_kwmatch (
    .word_buf_i (word_buf_q_i),
    .wlen_i     (wlen_q_i),
    .hit_o      (kw_hit),
    .idx_o      (kw_idx)
  );

  assign line_wide = {{LINE_OUT_W{1'b0}}, line_q_i};
  assign line_out  = line_wide[LINE_OUT_W-1:0];

  always_comb begin
    is_end      = (op_i == OP_END);
    is_digit    = ch_i inside {[CH_ZERO:CH_NINE]};
    is_alpha    = ch_i inside {[CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z]};
    is_alnum    = is_digit || is_alpha;
    is_blank    = ch_i inside {CH_SPACE, CH_TAB};
    is_nl       = (ch_i == CH_NL);
    is_slash    = (ch_i == CH_SLASH);
    is_bslash   = (ch_i == CH_BSLASH);
    digit       = 4'(ch_i - CH_ZERO);
    regex_close = is_slash && !bs_q_i;
    acc_ext     = {4'b0, acc_q_i};
    acc_mul     = (acc_ext << 3) + (acc_ext << 1) + AccW'(digit);

    tok_close = 1'b0;
    fresh     = 1'b0;
    first_vld = 1'b0;
    if (is_end) begin
      tok_close = (mode_q_i != MODE_IDLE);
      first_vld = tok_close;
    end else begin
      case (mode_q_i)
        MODE_NUMBER: begin
          tok_close = !is_digit;
          fresh     = !is_digit;
          first_vld = !is_digit;
        end
        MODE_WORD: begin
          tok_close = !is_alnum;
          fresh     = !is_alnum;
          first_vld = 1'b1;
        end
        MODE_REGEX: begin
          tok_close = regex_close;
          first_vld = 1'b1;
        end
        default: begin
          fresh = 1'b1;
        end
      endcase
    end
    second_vld = fresh && !is_blank && !is_nl && !is_digit && !is_slash;
  end

  always_comb begin
    mode_d_o     = mode_q_i;
    acc_d_o      = acc_q_i;
    ovf_d_o      = ovf_q_i;
    wlen_d_o     = wlen_q_i;
    bs_d_o       = bs_q_i;
    word_buf_d_o = word_buf_q_i;
    line_d_o     = line_q_i;

    if (!is_end) begin
      case (mode_q_i)
        MODE_NUMBER: begin
          if (is_digit) begin
            if (acc_mul > AccW'(NUM_MAX)) begin
              acc_d_o = NUM_MAX;
              ovf_d_o = 1'b1;
            end else begin
              acc_d_o = acc_mul[NUM_W-1:0];
            end
          end
        end
        MODE_WORD: begin
          if (is_alnum) begin
            if (32'(wlen_q_i) < MAX_KEYWORD_LEN) begin
              for (int j = 0; j < MAX_KEYWORD_LEN; j++) begin
                if (32'(wlen_q_i) == j) begin
                  word_buf_d_o[8*j +: 8] = ch_i;
                end
              end
              wlen_d_o = wlen_q_i + WLEN_W'(1);
            end else begin
              wlen_d_o = WLEN_W'(MAX_KEYWORD_LEN + 1);
            end
          end
        end
        MODE_REGEX: begin
          bs_d_o = is_bslash;
        end
        default: begin
        end
      endcase
    end

    if (tok_close) begin
      mode_d_o = MODE_IDLE;
      acc_d_o  = '0;
      ovf_d_o  = 1'b0;
      wlen_d_o = '0;
      bs_d_o   = 1'b0;
    end

    if (fresh) begin
      if (is_nl) begin
        if (line_q_i != {LINE_BITS{1'b1}}) begin
          line_d_o = line_q_i + LINE_BITS'(1);
        end
      end else if (is_digit) begin
        mode_d_o = MODE_NUMBER;
        acc_d_o  = NUM_W'(digit);
        ovf_d_o  = 1'b0;
      end else if (is_alpha) begin
        mode_d_o            = MODE_WORD;
        word_buf_d_o[7:0]   = ch_i;
        wlen_d_o            = WLEN_W'(1);
      end else if (is_slash) begin
        mode_d_o = MODE_REGEX;
        bs_d_o   = 1'b0;
      end
    end
  end

  always_comb begin
    if (kw_hit) begin
      word_end_res = make_result(KIND_KEYWORD, kw_idx, '0, 1'b0, '0, line_out);
    end else begin
      word_end_res = make_result(KIND_IDENT, '0, '0, 1'b0, '0, line_out);
    end

    first_res = make_result(KIND_TEXT, '0, '0, 1'b0, ch_i, line_out);
    case (mode_q_i)
      MODE_NUMBER: first_res = make_result(KIND_NUMBER, '0, acc_q_i, ovf_q_i, '0, line_out);
      MODE_WORD: begin
        if (tok_close) begin
          first_res = word_end_res;
        end
      end
      MODE_REGEX: begin
        if (is_end) begin
          first_res = make_result(KIND_UNTERM, '0, '0, 1'b0, '0, line_out);
        end else if (tok_close) begin
          first_res = make_result(KIND_REGEX_END, '0, '0, 1'b0, '0, line_out);
        end
      end
      default: begin
      end
    endcase

    if (is_alpha) begin
      second_res = make_result(KIND_TEXT, '0, '0, 1'b0, ch_i, line_out);
    end else begin
      second_res = make_result(KIND_SINGLE, '0, '0, 1'b0, ch_i, line_out);
    end

    push_n_o = 2'(first_vld) + 2'(second_vld);
    res0_o   = first_vld ? first_res : second_res;
    res1_o   = second_res;
    res0_o.last = !(first_vld && second_vld);
    res1_o.last = 1'b1;
  end

endmodule

/* rtl/tok_outq.sv */
// ----------------------------------------------------------------------------
// tok_outq
// Three-slot shifting result queue; takes up to two results per cycle.
// ----------------------------------------------------------------------------
module tok_outq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [1:0]            push_n_i,
  input  tok_pkg::tok_result_t  res0_i,
  input  tok_pkg::tok_result_t  res1_i,
  input  logic                  pop_i,
  output tok_pkg::tok_result_t  head_o,
  output logic [1:0]            cnt_o
);
  import tok_pkg::*;

  localparam int QDepth = 3;

  tok_result_t slot_q [QDepth];
  tok_result_t slot_d [QDepth];
  logic [1:0]  cnt_q, cnt_d, base;

  always_comb begin
    base  = cnt_q - 2'(pop_i);
    cnt_d = base + push_n_i;
    for (int i = 0; i < QDepth; i++) begin
      if (pop_i && (i < QDepth - 1)) begin
        slot_d[i] = slot_q[(i + 1) % QDepth];
      end else begin
        slot_d[i] = slot_q[i];
      end
      if ((push_n_i != 2'd0) && (32'(base) == i)) begin
        slot_d[i] = res0_i;
      end
      if ((push_n_i == 2'd2) && (32'(base) + 1 == i)) begin
        slot_d[i] = res1_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDepth; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  assign head_o = slot_q[0];
  assign cnt_o  = cnt_q;

endmodule

/* rtl/query_language_tokenizer.sv */
// ----------------------------------------------------------------------------
// query_language_tokenizer
// Byte-stream tokenizer: numbers, words and keywords, regex text, single chars.
// ----------------------------------------------------------------------------
// Each accepted request writes its results into the registered result queue.
// Throughput: one request per cycle while not stalled; a request yields zero to two results.
// The three-slot result queue sets the rate: requests stall while it holds two or more.
// Reset (asynchronous, active low): idle scan, empty queue, line counter at one;
// the keyword prefix buffer is not cleared.
module query_language_tokenizer #(
  parameter int LINE_BITS       = tok_pkg::LINE_BITS_DEF,
  parameter int MAX_KEYWORD_LEN = tok_pkg::MAX_KEYWORD_LEN_DEF,
  parameter int KEYWORD_COUNT   = tok_pkg::KEYWORD_COUNT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              op_i,
  input  logic [tok_pkg::CHAR_W-1:0]        ch_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tok_pkg::KIND_W-1:0]        kind_o,
  output logic [tok_pkg::KW_IDX_W-1:0]      keyword_index_o,
  output logic [tok_pkg::NUM_W-1:0]         number_value_o,
  output logic                              number_saturated_o,
  output logic [tok_pkg::CHAR_W-1:0]        char_value_o,
  output logic [tok_pkg::LINE_OUT_W-1:0]    line_number_o,
  output logic                              last_of_run_o
);
  import tok_pkg::*;

  localparam int WlenW  = $clog2(MAX_KEYWORD_LEN + 2);
  localparam int KwUsed = (KEYWORD_COUNT < KW_TABLE_SIZE) ? KEYWORD_COUNT : KW_TABLE_SIZE;

  tok_mode_e                    mode_q, mode_d;
  logic [NUM_W-1:0]             acc_q, acc_d;
  logic                         ovf_q, ovf_d;
  logic [WlenW-1:0]             wlen_q, wlen_d;
  logic                         bs_q, bs_d;
  logic [MAX_KEYWORD_LEN*8-1:0] word_buf_q, word_buf_d;
  logic [LINE_BITS-1:0]         line_q, line_d;
  logic [1:0]                   step_push, push_n, q_cnt;
  logic                         accept, pop;
  tok_result_t                  res0, res1, head;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = q_cnt[1];
  assign push_n     = accept ? step_push : 2'd0;
  assign pop        = out_valid_o && !out_stall_i;

  tok_step #(
    .LINE_BITS       (LINE_BITS),
    .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN),
    .KEYWORD_COUNT   (KEYWORD_COUNT),
    .WLEN_W          (WlenW)
  ) u_step (
    .op_i         (op_i),
    .ch_i         (ch_i),
    .mode_q_i     (mode_q),
    .acc_q_i      (acc_q),
    .ovf_q_i      (ovf_q),
    .wlen_q_i     (wlen_q),
    .bs_q_i       (bs_q),
    .word_buf_q_i (word_buf_q),
    .line_q_i     (line_q),
    .mode_d_o     (mode_d),
    .acc_d_o      (acc_d),
    .ovf_d_o      (ovf_d),
    .wlen_d_o     (wlen_d),
    .bs_d_o       (bs_d),
    .word_buf_d_o (word_buf_d),
    .line_d_o     (line_d),
    .push_n_o     (step_push),
    .res0_o       (res0),
    .res1_o       (res1)
  );

  tok_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .res0_i   (res0),
    .res1_i   (res1),
    .pop_i    (pop),
    .head_o   (head),
    .cnt_o    (q_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      acc_q  <= '0;
      ovf_q  <= 1'b0;
      wlen_q <= '0;
      bs_q   <= 1'b0;
      line_q <= LINE_BITS'(1);
    end else if (accept) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      ovf_q  <= ovf_d;
      wlen_q <= wlen_d;
      bs_q   <= bs_d;
      line_q <= line_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_buf_q <= word_buf_d;
    end
  end

  assign out_valid_o        = (q_cnt != 2'd0);
  assign kind_o             = head.kind;
  assign keyword_index_o    = head.kw_idx;
  assign number_value_o     = head.num;
  assign number_saturated_o = head.sat;
  assign char_value_o       = head.chr;
  assign line_number_o      = head.line;
  assign last_of_run_o      = head.last;

  a_pair_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> q_cnt >= 2'd2)
    else $error("first of a result pair without its partner queued");

  a_line_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> line_q >= $past(line_q))
    else $error("line counter went backwards");

  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op_i == OP_END) |=> mode_q == MODE_IDLE && wlen_q == '0)
    else $error("scanner not idle after end of input");

  a_kw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_KEYWORD) |-> 32'(keyword_index_o) < KwUsed)
    else $error("keyword index outside table");

endmodule
